FILE: rtl/core/errs_pkg.sv
// ----------------------------------------------------------------------------
// errs_pkg
// Types, widths and constants shared by the echo reply RTT statistics block.
// ----------------------------------------------------------------------------
package errs_pkg;

  localparam int TimestampBytesDef = 16;
  localparam int RttBitsDef        = 24;

  localparam int OpW      = 1;
  localparam int FlenW    = 16;
  localparam int HdrW     = 4;
  localparam int TypeW    = 8;
  localparam int IdW      = 16;
  localparam int RttInW   = 24;

  localparam int CountW   = 32;
  localparam int TotalW   = 56;
  localparam int SquareW  = 64;
  localparam int LossW    = 10;
  localparam int LossNumW = 42;
  localparam int OutRttW  = 24;
  localparam int MulW     = 32;

  localparam int Ipv4MinHdr = 20;
  localparam int IcmpHdr    = 8;
  localparam int MinFrame   = Ipv4MinHdr + IcmpHdr;

  localparam logic [OpW-1:0]   OpRequest     = 1'b0;
  localparam logic [OpW-1:0]   OpReply       = 1'b1;
  localparam logic [TypeW-1:0] IcmpEchoReply = 8'd0;

  typedef struct packed {
    logic [OpW-1:0]    operation;
    logic [FlenW-1:0]  frame_length;
    logic [HdrW-1:0]   ip_header_words;
    logic [TypeW-1:0]  icmp_type;
    logic [IdW-1:0]    reply_identifier;
    logic [RttInW-1:0] rtt_us;
  } errs_in_t;

  typedef struct packed {
    logic               accepted;
    logic [CountW-1:0]  sent_total;
    logic [CountW-1:0]  received_total;
    logic [LossW-1:0]   loss_tenths_percent;
    logic [OutRttW-1:0] min_rtt_us;
    logic [OutRttW-1:0] max_rtt_us;
    logic [OutRttW-1:0] avg_rtt_us;
    logic [OutRttW-1:0] stddev_rtt_us;
  } errs_out_t;

  typedef logic [IdW-1:0] errs_cfg_t;

  typedef struct packed {
    logic busy;
    logic done;
  } errs_unit_sts_t;

endpackage

FILE: rtl/core/errs_chan_if.sv
// ----------------------------------------------------------------------------
// errs_chan_if
// Valid/ready channel carrying one payload word per transfer.
// ----------------------------------------------------------------------------
interface errs_chan_if #(
  parameter type data_t = logic
);
  logic  valid;
  logic  ready;
  data_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/core/errs_mul.sv
// ----------------------------------------------------------------------------
// errs_mul
// Radix-4 shift-add multiplier: two multiplier bits per cycle.
// ----------------------------------------------------------------------------
module errs_mul #(
  parameter int W = 32
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic [W-1:0]            a,
  input  logic [W-1:0]            b,
  output logic [2*W-1:0]          prod,
  output errs_pkg::errs_unit_sts_t sts
);
  import errs_pkg::*;

  localparam int Steps = W / 2;
  localparam int CntW  = (Steps > 1) ? $clog2(Steps) : 1;
  localparam logic [CntW-1:0] LastCnt = CntW'(Steps - 1);

  logic [2*W-1:0] p_r;
  logic [W-1:0]   a_r;
  logic [CntW-1:0] cnt_r;
  logic           busy_r;
  logic           done_r;
  logic [W+1:0]   addend;
  logic [W+1:0]   sum;
  logic [2*W-1:0] p_nxt;

  always_comb begin
    addend = '0;
    if (p_r[0]) begin
      addend = addend + {2'b00, a_r};
    end
    if (p_r[1]) begin
      addend = addend + {1'b0, a_r, 1'b0};
    end
    sum   = {2'b00, p_r[2*W-1:W]} + addend;
    p_nxt = {sum, p_r[W-1:2]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CntW'(1);
        if (cnt_r == LastCnt) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      p_r <= {{W{1'b0}}, b};
      a_r <= a;
    end else if (busy_r) begin
      p_r <= p_nxt;
    end
  end

  assign prod     = p_r;
  assign sts.busy = busy_r;
  assign sts.done = done_r;

endmodule

FILE: rtl/core/errs_div.sv
// ----------------------------------------------------------------------------
// errs_div
// Restoring divider: one quotient bit per cycle.
// ----------------------------------------------------------------------------
module errs_div #(
  parameter int NW = 64,
  parameter int DW = 32
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic [NW-1:0]           num,
  input  logic [DW-1:0]           den,
  output logic [NW-1:0]           quo,
  output errs_pkg::errs_unit_sts_t sts
);
  import errs_pkg::*;

  localparam int CntW = $clog2(NW);
  localparam logic [CntW-1:0] LastCnt = CntW'(NW - 1);

  logic [NW-1:0]   quo_r;
  logic [DW-1:0]   rem_r;
  logic [DW-1:0]   den_r;
  logic [CntW-1:0] cnt_r;
  logic            busy_r;
  logic            done_r;
  logic [DW:0]     trial;
  logic [DW:0]     diff;
  logic            ge;
  logic [DW-1:0]   rem_nxt;

  always_comb begin
    trial   = {rem_r, quo_r[NW-1]};
    diff    = trial - {1'b0, den_r};
    ge      = trial >= {1'b0, den_r};
    rem_nxt = ge ? diff[DW-1:0] : trial[DW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CntW'(1);
        if (cnt_r == LastCnt) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (busy_r) begin
      quo_r <= {quo_r[NW-2:0], ge};
      rem_r <= rem_nxt;
    end
  end

  assign quo      = quo_r;
  assign sts.busy = busy_r;
  assign sts.done = done_r;

endmodule

FILE: rtl/core/errs_sqrt.sv
// ----------------------------------------------------------------------------
// errs_sqrt
// Integer square root: two radicand bits per cycle.
// ----------------------------------------------------------------------------
module errs_sqrt #(
  parameter int VW = 64
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic [VW-1:0]           radicand,
  output logic [VW/2-1:0]         root,
  output errs_pkg::errs_unit_sts_t sts
);
  import errs_pkg::*;

  localparam int RW   = VW / 2;
  localparam int CntW = $clog2(RW);
  localparam logic [CntW-1:0] LastCnt = CntW'(RW - 1);

  logic [VW-1:0]   v_r;
  logic [RW+1:0]   rem_r;
  logic [RW-1:0]   root_r;
  logic [CntW-1:0] cnt_r;
  logic            busy_r;
  logic            done_r;
  logic [RW+3:0]   t;
  logic [RW+3:0]   trial;
  logic [RW+3:0]   diff;
  logic            ge;
  logic [RW+1:0]   rem_nxt;

  always_comb begin
    t       = {rem_r, v_r[VW-1:VW-2]};
    trial   = {2'b00, root_r, 2'b01};
    diff    = t - trial;
    ge      = t >= trial;
    rem_nxt = ge ? diff[RW+1:0] : t[RW+1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CntW'(1);
        if (cnt_r == LastCnt) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      v_r    <= radicand;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      v_r    <= {v_r[VW-3:0], 2'b00};
      rem_r  <= rem_nxt;
      root_r <= {root_r[RW-2:0], ge};
    end
  end

  assign root     = root_r;
  assign sts.busy = busy_r;
  assign sts.done = done_r;

endmodule

FILE: rtl/core/echo_reply_rtt_statistics.sv
// ----------------------------------------------------------------------------
// echo_reply_rtt_statistics
// Ping statistics: counts requests and matching echo replies, tracks RTT
// min/max/sum/sum of squares, and reports loss, min, avg, max and stddev.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch   one event per transfer: a request sent or a reply summary.
//   out_ch  one result per event: counts, loss in tenths of a percent and
//           RTT min/avg/max/stddev in microseconds.
//   cfg_ch  write of own_identifier; always ready, write it while idle.
// Sequence: the state update and the serial units run back to back: a radix-4
//   square of the RTT, a bit-serial divide (mean and mean square in parallel,
//   loss alongside), a square of the mean and a root. One item is in work at a
//   time; in_ch.ready is high when no item is in work, so the next item may
//   transfer while the previous result waits.
// Stall: a result waits in the output register until out_ch.ready; a
//   finished item holds in its last step until that register is free.
// Reset: all counts, sums, extremes and own_identifier clear to zero, the
//   output register empties and the block is ready in the next cycle.
// ----------------------------------------------------------------------------
module echo_reply_rtt_statistics #(
  parameter int TIMESTAMP_BYTES = errs_pkg::TimestampBytesDef,
  parameter int RTT_BITS        = errs_pkg::RttBitsDef
) (
  input  logic        clk,
  input  logic        rst_n,
  errs_chan_if.sink   in_ch,
  errs_chan_if.source out_ch,
  errs_chan_if.sink   cfg_ch
);
  import errs_pkg::*;

  localparam int RttW = (RTT_BITS < RttInW) ? RTT_BITS : RttInW;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SQR  = 3'd1;
  localparam logic [2:0] S_ACC  = 3'd2;
  localparam logic [2:0] S_DIVS = 3'd3;
  localparam logic [2:0] S_DIVW = 3'd4;
  localparam logic [2:0] S_AVSQ = 3'd5;
  localparam logic [2:0] S_ROOT = 3'd6;
  localparam logic [2:0] S_DONE = 3'd7;

  logic [2:0]         state_r;
  logic [IdW-1:0]     own_id_r;
  logic [CountW-1:0]  sent_r;
  logic [CountW-1:0]  recv_r;
  logic [RttW-1:0]    min_r;
  logic [RttW-1:0]    max_r;
  logic [TotalW-1:0]  total_r;
  logic [SquareW-1:0] sq_r;
  logic               acc_r;
  logic [CountW-1:0]  loss_diff_r;
  logic               loss_on_r;
  logic               sd_on_r;
  logic               out_valid_r;
  errs_out_t          out_r;

  errs_in_t           in_d;
  logic               in_xfer;
  logic [6:0]         body_min;
  logic [7:0]         ts_min;
  logic               reply_ok;
  logic [RttW-1:0]    rtt_val;
  logic [TotalW:0]    total_sum;
  logic [SquareW:0]   sq_sum;
  logic [LossNumW-1:0] loss_ext;
  logic [LossNumW-1:0] loss_num;
  logic               out_free;
  logic               load_out;
  logic               recv_nz;

  logic               mul_start;
  logic [MulW-1:0]    mul_op;
  logic [2*MulW-1:0]  mul_prod;
  errs_unit_sts_t     mul_sts;
  logic               div_start;
  logic [SquareW-1:0] avg_q;
  logic [SquareW-1:0] msq_q;
  logic [LossNumW-1:0] loss_q;
  errs_unit_sts_t     avg_sts;
  errs_unit_sts_t     msq_sts;
  errs_unit_sts_t     loss_sts;
  logic               sqrt_start;
  logic [SquareW-1:0] sqrt_in;
  logic [SquareW/2-1:0] root;
  errs_unit_sts_t     sqrt_sts;

  assign in_d    = in_ch.data;
  assign in_xfer = in_ch.valid && in_ch.ready;

  always_comb begin
    body_min = {1'b0, in_d.ip_header_words, 2'b00} + 7'(IcmpHdr);
    ts_min   = {1'b0, body_min} + 8'(TIMESTAMP_BYTES);
    reply_ok = (in_d.operation == OpReply) &&
               (in_d.frame_length >= FlenW'(MinFrame)) &&
               (in_d.frame_length >= FlenW'(body_min)) &&
               (in_d.icmp_type == IcmpEchoReply) &&
               (in_d.reply_identifier == own_id_r);
    rtt_val  = (in_d.frame_length >= FlenW'(ts_min)) ? in_d.rtt_us[RttW-1:0] : '0;
    total_sum = {1'b0, total_r} + (TotalW+1)'(rtt_val);
    sq_sum    = {1'b0, sq_r} + {1'b0, mul_prod};
    loss_ext  = LossNumW'(loss_diff_r);
    loss_num  = (loss_ext << 10) - (loss_ext << 5) + (loss_ext << 3);
  end

  assign mul_start  = in_xfer || ((state_r == S_DIVW) && avg_sts.done);
  assign mul_op     = (state_r == S_IDLE) ? MulW'(rtt_val) : avg_q[MulW-1:0];
  assign div_start  = (state_r == S_DIVS);
  assign sqrt_start = (state_r == S_AVSQ) && mul_sts.done;
  assign sqrt_in    = msq_q - mul_prod;

  errs_mul #(.W(MulW)) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_op),
    .b     (mul_op),
    .prod  (mul_prod),
    .sts   (mul_sts)
  );

  errs_div #(.NW(SquareW), .DW(CountW)) u_div_avg (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (SquareW'(total_r)),
    .den   (recv_r),
    .quo   (avg_q),
    .sts   (avg_sts)
  );

  errs_div #(.NW(SquareW), .DW(CountW)) u_div_msq (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (sq_r),
    .den   (recv_r),
    .quo   (msq_q),
    .sts   (msq_sts)
  );

  errs_div #(.NW(LossNumW), .DW(CountW)) u_div_loss (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (loss_num),
    .den   (sent_r),
    .quo   (loss_q),
    .sts   (loss_sts)
  );

  errs_sqrt #(.VW(SquareW)) u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sqrt_start),
    .radicand (sqrt_in),
    .root     (root),
    .sts      (sqrt_sts)
  );

  assign out_free = !out_valid_r || out_ch.ready;
  assign load_out = (state_r == S_DONE) && out_free;
  assign recv_nz  = (recv_r != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      own_id_r    <= '0;
      sent_r      <= '0;
      recv_r      <= '0;
      min_r       <= '0;
      max_r       <= '0;
      total_r     <= '0;
      sq_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        own_id_r <= cfg_ch.data;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_xfer) begin
            state_r <= S_SQR;
            if (in_d.operation == OpRequest) begin
              sent_r <= (sent_r == '1) ? sent_r : sent_r + CountW'(1);
            end else if (reply_ok) begin
              recv_r <= (recv_r == '1) ? recv_r : recv_r + CountW'(1);
              if (!recv_nz) begin
                min_r <= rtt_val;
                max_r <= rtt_val;
              end else begin
                if (rtt_val < min_r) begin
                  min_r <= rtt_val;
                end
                if (rtt_val > max_r) begin
                  max_r <= rtt_val;
                end
              end
              total_r <= total_sum[TotalW] ? '1 : total_sum[TotalW-1:0];
            end
          end
        end
        S_SQR: begin
          if (mul_sts.done) begin
            state_r <= S_ACC;
          end
        end
        S_ACC: begin
          if (acc_r) begin
            sq_r <= sq_sum[SquareW] ? '1 : sq_sum[SquareW-1:0];
          end
          state_r <= S_DIVS;
        end
        S_DIVS: begin
          state_r <= S_DIVW;
        end
        S_DIVW: begin
          if (avg_sts.done) begin
            state_r <= S_AVSQ;
          end
        end
        S_AVSQ: begin
          if (mul_sts.done) begin
            state_r <= S_ROOT;
          end
        end
        S_ROOT: begin
          if (sqrt_sts.done) begin
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      acc_r <= reply_ok;
    end
    if (state_r == S_ACC) begin
      loss_diff_r <= sent_r - recv_r;
      loss_on_r   <= (sent_r != '0) && (recv_r < sent_r);
    end
    if (sqrt_start) begin
      sd_on_r <= (avg_q[SquareW-1:MulW] == '0) && (msq_q > mul_prod) &&
                 (recv_r > CountW'(1));
    end
    if (load_out) begin
      out_r.accepted            <= acc_r;
      out_r.sent_total          <= sent_r;
      out_r.received_total      <= recv_r;
      out_r.loss_tenths_percent <= loss_on_r ? loss_q[LossW-1:0] : '0;
      out_r.min_rtt_us          <= recv_nz ? OutRttW'(min_r) : '0;
      out_r.max_rtt_us          <= recv_nz ? OutRttW'(max_r) : '0;
      if (!recv_nz) begin
        out_r.avg_rtt_us <= '0;
      end else if (avg_q[SquareW-1:OutRttW] != '0) begin
        out_r.avg_rtt_us <= '1;
      end else begin
        out_r.avg_rtt_us <= avg_q[OutRttW-1:0];
      end
      if (!sd_on_r) begin
        out_r.stddev_rtt_us <= '0;
      end else if (root[SquareW/2-1:OutRttW] != '0) begin
        out_r.stddev_rtt_us <= '1;
      end else begin
        out_r.stddev_rtt_us <= root[OutRttW-1:0];
      end
    end
  end

  assign in_ch.ready  = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_r;

  a_busy_after_accept: assert property (
    @(posedge clk) disable iff (!rst_n) in_xfer |=> !in_ch.ready
  ) else $error("input taken while an item is in work");

  a_result_from_done: assert property (
    @(posedge clk) disable iff (!rst_n) $rose(out_ch.valid) |-> $past(state_r) == S_DONE
  ) else $error("result presented outside the final step");

  a_accepted_counted: assert property (
    @(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.data.accepted |-> out_ch.data.received_total != '0
  ) else $error("accepted reply with zero reply count");

  a_units_in_order: assert property (
    @(posedge clk) disable iff (!rst_n)
    mul_sts.busy |-> !sqrt_sts.busy && !avg_sts.busy && !msq_sts.busy
  ) else $error("multiplier overlaps divider or root");

  a_loss_before_avg_square: assert property (
    @(posedge clk) disable iff (!rst_n) state_r == S_AVSQ |-> !loss_sts.busy
  ) else $error("loss divide still running at mean square");

endmodule

FILE: bench/tb_echo_reply_rtt_statistics.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_echo_reply_rtt_statistics
// Self-checking bench for the ping statistics block. Requests and reply
// summaries go in over the event channel. A local predictor keeps its own
// counts, RTT extremes and sums and works out each expected result. Results
// are compared field by field in order. Directed cases cover short frames,
// missing timestamps, rejects, loss clamping and identifier extremes. Random
// phases follow with varied source and sink idling and a long sink stall.
// ----------------------------------------------------------------------------
module tb_echo_reply_rtt_statistics;
  import errs_pkg::*;

  localparam int          CYCLE_LIMIT = 1_500_000;
  localparam int          DRAIN_WAIT  = 160;
  localparam logic [63:0] COUNT_MAX   = 64'h0000_0000_FFFF_FFFF;
  localparam logic [63:0] TOTAL_MAX   = 64'h00FF_FFFF_FFFF_FFFF;
  localparam logic [63:0] SQUARE_MAX  = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] OUT_MAX     = 64'h0000_0000_00FF_FFFF;

  logic clk;
  logic rst_n;

  errs_chan_if #(.data_t(errs_in_t))  in_if ();
  errs_chan_if #(.data_t(errs_out_t)) out_if ();
  errs_chan_if #(.data_t(errs_cfg_t)) cfg_if ();

  echo_reply_rtt_statistics DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if.sink),
    .out_ch (out_if.source),
    .cfg_ch (cfg_if.sink)
  );

  // predictor state
  logic [IdW-1:0] own_id;
  logic [63:0]    sent_cnt;
  logic [63:0]    recv_cnt;
  logic [63:0]    rtt_low;
  logic [63:0]    rtt_high;
  logic [63:0]    rtt_sum;
  logic [63:0]    rtt_sq_sum;

  errs_out_t pending_stats[$];
  errs_out_t got_stats;
  errs_out_t want_stats;

  int src_idle_pct;
  int snk_idle_pct;
  int hold_left;
  int cycle_count;
  int mismatches;
  int events_sent;
  int stats_checked;
  int replies_accepted;
  int id_settings;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t ns: timeout after %0d cycles", $time, cycle_count);
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic logic [63:0] sat_add(logic [63:0] a, logic [63:0] b,
                                          logic [63:0] lim);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s > {1'b0, lim}) return lim;
    return s[63:0];
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [31:0] r;
    logic [63:0] t;
    r = '0;
    for (int b = 31; b >= 0; b--) begin
      t = {32'd0, r | (32'd1 << b)};
      if (t * t <= v) r = r | (32'd1 << b);
    end
    return {32'd0, r};
  endfunction

  function automatic logic [OutRttW-1:0] clip_out(logic [63:0] v);
    return (v > OUT_MAX) ? OUT_MAX[OutRttW-1:0] : v[OutRttW-1:0];
  endfunction

  // update the statistics with one event and return the expected result
  function automatic errs_out_t advance_stats(errs_in_t ev);
    errs_out_t   r;
    logic [63:0] flen;
    logic [63:0] hbytes;
    logic [63:0] rtt;
    logic [63:0] avg;
    logic [63:0] msq;
    logic [63:0] avg_sq;
    r      = '0;
    flen   = {48'd0, ev.frame_length};
    hbytes = {58'd0, ev.ip_header_words, 2'b00};
    if (ev.operation == OpRequest) begin
      sent_cnt = sat_add(sent_cnt, 64'd1, COUNT_MAX);
    end else if (flen >= MinFrame && flen >= hbytes + IcmpHdr &&
                 ev.icmp_type == IcmpEchoReply && ev.reply_identifier == own_id) begin
      rtt = (flen >= hbytes + IcmpHdr + TimestampBytesDef) ? {40'd0, ev.rtt_us} : 64'd0;
      r.accepted = 1'b1;
      if (recv_cnt == 0) begin
        rtt_low  = rtt;
        rtt_high = rtt;
      end else begin
        if (rtt < rtt_low) rtt_low = rtt;
        if (rtt > rtt_high) rtt_high = rtt;
      end
      recv_cnt   = sat_add(recv_cnt, 64'd1, COUNT_MAX);
      rtt_sum    = sat_add(rtt_sum, rtt, TOTAL_MAX);
      rtt_sq_sum = sat_add(rtt_sq_sum, rtt * rtt, SQUARE_MAX);
    end
    r.sent_total     = sent_cnt[CountW-1:0];
    r.received_total = recv_cnt[CountW-1:0];
    if (sent_cnt > 0 && recv_cnt < sent_cnt)
      r.loss_tenths_percent = LossW'((64'd1000 * (sent_cnt - recv_cnt)) / sent_cnt);
    if (recv_cnt > 0) begin
      avg          = rtt_sum / recv_cnt;
      r.min_rtt_us = clip_out(rtt_low);
      r.max_rtt_us = clip_out(rtt_high);
      r.avg_rtt_us = clip_out(avg);
      if (recv_cnt > 1) begin
        msq    = rtt_sq_sum / recv_cnt;
        avg_sq = (avg > COUNT_MAX) ? SQUARE_MAX : avg * avg;
        r.stddev_rtt_us = clip_out((msq > avg_sq) ? int_sqrt(msq - avg_sq) : 64'd0);
      end
    end
    return r;
  endfunction

  task automatic compare_field(input string fname, input logic [63:0] want,
                               input logic [63:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %0h actual %0h", $time, fname, want, got);
      mismatches++;
    end
  endtask

  // sink: random ready, or a counted hold-off
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_if.ready = 1'b0;
        hold_left--;
      end else begin
        out_if.ready = ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      got_stats = out_if.data;
      if (pending_stats.size() == 0) begin
        $display("%0t ns: result with nothing expected, actual %h", $time, got_stats);
        mismatches++;
      end else begin
        want_stats = pending_stats.pop_front();
        compare_field("accepted", want_stats.accepted, got_stats.accepted);
        compare_field("sent_total", want_stats.sent_total, got_stats.sent_total);
        compare_field("received_total", want_stats.received_total,
                      got_stats.received_total);
        compare_field("loss_tenths_percent", want_stats.loss_tenths_percent,
                      got_stats.loss_tenths_percent);
        compare_field("min_rtt_us", want_stats.min_rtt_us, got_stats.min_rtt_us);
        compare_field("max_rtt_us", want_stats.max_rtt_us, got_stats.max_rtt_us);
        compare_field("avg_rtt_us", want_stats.avg_rtt_us, got_stats.avg_rtt_us);
        compare_field("stddev_rtt_us", want_stats.stddev_rtt_us, got_stats.stddev_rtt_us);
      end
      stats_checked++;
    end
  end

  task automatic send_event(input errs_in_t ev);
    @(negedge clk);
    while ($urandom_range(99) < src_idle_pct) @(negedge clk);
    in_if.valid = 1'b1;
    in_if.data  = ev;
    do @(posedge clk); while (!in_if.ready);
    pending_stats.push_back(advance_stats(ev));
    if (pending_stats[$].accepted) replies_accepted++;
    events_sent++;
    @(negedge clk);
    in_if.valid = 1'b0;
  endtask

  task automatic write_own_id(input logic [IdW-1:0] id);
    @(negedge clk);
    cfg_if.valid = 1'b1;
    cfg_if.data  = id;
    do @(posedge clk); while (!cfg_if.ready);
    own_id = id;
    id_settings++;
    @(negedge clk);
    cfg_if.valid = 1'b0;
  endtask

  task automatic wait_idle();
    while (pending_stats.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  function automatic errs_in_t reply_ev(int flen, int hw, int itype, int id, int rtt);
    errs_in_t ev;
    ev.operation        = OpReply;
    ev.frame_length     = FlenW'(flen);
    ev.ip_header_words  = HdrW'(hw);
    ev.icmp_type        = TypeW'(itype);
    ev.reply_identifier = IdW'(id);
    ev.rtt_us           = RttInW'(rtt);
    return ev;
  endfunction

  function automatic errs_in_t request_ev();
    errs_in_t ev;
    ev           = errs_in_t'({$urandom, $urandom, $urandom});
    ev.operation = OpRequest;
    return ev;
  endfunction

  function automatic errs_in_t random_ev();
    errs_in_t ev;
    int       pick;
    int       hbytes;
    int       lo;
    int       ts_min;
    int       sub;
    pick = $urandom_range(99);
    if (pick < 40) return request_ev();
    ev = errs_in_t'({$urandom, $urandom, $urandom});
    ev.operation = OpReply;
    if (pick < 85) begin
      hbytes = int'(ev.ip_header_words) * 4;
      lo     = (hbytes + IcmpHdr > MinFrame) ? hbytes + IcmpHdr : MinFrame;
      ts_min = (hbytes + IcmpHdr + TimestampBytesDef > MinFrame) ?
               hbytes + IcmpHdr + TimestampBytesDef : MinFrame;
      sub = $urandom_range(99);
      if (sub < 70)
        ev.frame_length = FlenW'($urandom_range(1500, ts_min));
      else if (sub < 85 && lo < ts_min)
        ev.frame_length = FlenW'($urandom_range(ts_min - 1, lo));
      else
        ev.frame_length = FlenW'($urandom_range(65535, lo));
      ev.icmp_type        = IcmpEchoReply;
      ev.reply_identifier = own_id;
      sub = $urandom_range(99);
      if (sub < 30)      ev.rtt_us = RttInW'($urandom_range(2000));
      else if (sub < 40) ev.rtt_us = '0;
      else if (sub < 50) ev.rtt_us = '1;
    end else if (pick < 92) begin
      // right type and identifier, random length
      ev.icmp_type        = IcmpEchoReply;
      ev.reply_identifier = own_id;
    end
    return ev;
  endfunction

  task automatic test_first_replies();
    write_own_id(16'h0000);
    // replies before any request: loss clamps, stddev waits for two replies
    send_event(reply_ev(65535, 15, IcmpEchoReply, 0, 24'hFFFFFF));
    send_event(reply_ev(65535, 15, IcmpEchoReply, 0, 0));
    send_event(reply_ev(100, 5, IcmpEchoReply, 0, 24'h800000));
    send_event(request_ev());
    send_event(request_ev());
    send_event(request_ev());
    send_event(request_ev());
  endtask

  task automatic test_frame_lengths();
    send_event(reply_ev(27, 5, IcmpEchoReply, 0, 1234));
    send_event(reply_ev(0, 0, IcmpEchoReply, 0, 1234));
    send_event(reply_ev(67, 15, IcmpEchoReply, 0, 1234));
    send_event(reply_ev(68, 15, IcmpEchoReply, 0, 1234));
    send_event(reply_ev(83, 15, IcmpEchoReply, 0, 1234));
    send_event(reply_ev(84, 15, IcmpEchoReply, 0, 1234));
    send_event(reply_ev(28, 0, IcmpEchoReply, 0, 77));
    send_event(reply_ev(28, 5, IcmpEchoReply, 0, 77));
  endtask

  task automatic test_rejects();
    send_event(reply_ev(84, 5, 8, 0, 999));
    send_event(reply_ev(84, 5, 255, 0, 999));
    send_event(reply_ev(84, 5, IcmpEchoReply, 1, 999));
    send_event(reply_ev(65535, 15, 255, 65535, 24'hFFFFFF));
  endtask

  task automatic test_id_extremes();
    wait_idle();
    write_own_id(16'hFFFF);
    send_event(reply_ev(84, 5, IcmpEchoReply, 65535, 5000));
    send_event(reply_ev(84, 5, IcmpEchoReply, 0, 5000));
    send_event(request_ev());
  endtask

  task automatic test_random_phase(input int n, input int src_pct, input int snk_pct,
                                   input logic [IdW-1:0] id);
    wait_idle();
    write_own_id(id);
    src_idle_pct = src_pct;
    snk_idle_pct = snk_pct;
    repeat (n) send_event(random_ev());
  endtask

  task automatic test_output_stall();
    wait_idle();
    src_idle_pct = 0;
    snk_idle_pct = 0;
    @(posedge clk);
    hold_left = 700;
    repeat (8) send_event(random_ev());
  endtask

  initial begin
    rst_n         = 1'b0;
    in_if.valid   = 1'b0;
    in_if.data    = '0;
    cfg_if.valid  = 1'b0;
    cfg_if.data   = '0;
    own_id        = '0;
    sent_cnt      = '0;
    recv_cnt      = '0;
    rtt_low       = '0;
    rtt_high      = '0;
    rtt_sum       = '0;
    rtt_sq_sum    = '0;
    src_idle_pct  = 0;
    snk_idle_pct  = 0;
    hold_left     = 0;
    cycle_count   = 0;
    mismatches    = 0;
    events_sent   = 0;
    stats_checked = 0;
    replies_accepted = 0;
    id_settings   = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_first_replies();
    test_frame_lengths();
    test_rejects();
    test_id_extremes();
    test_random_phase(400, 14, 64, 16'hFFFF);
    test_output_stall();
    test_random_phase(400, 64, 14, 16'($urandom));
    test_random_phase(420, 0, 0, 16'h0000);
    wait_idle();

    $display("Sent %0d events (%0d accepted replies), checked %0d results,",
             events_sent, replies_accepted, stats_checked);
    $display("over %0d identifier settings with an output stall; %0d mismatches.",
             id_settings, mismatches);
    if (mismatches == 0 && pending_stats.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/core/errs_pkg.sv
rtl/core/errs_chan_if.sv
rtl/core/errs_mul.sv
rtl/core/errs_div.sv
rtl/core/errs_sqrt.sv
rtl/core/echo_reply_rtt_statistics.sv
bench/tb_echo_reply_rtt_statistics.sv
